>>> sv/mnb_pkg.sv
`timescale 1ns / 1ps

package mnb_pkg;

    localparam int NBINS  = 16;
    localparam int DIM    = 4;
    localparam int BIN_W  = 4;
    localparam int ROW_W  = 2;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 5;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = 104;
    localparam int DIST_W = 63;
    localparam int FRAC_W = 16;
    localparam int HALF_W = 32;

    localparam logic [1:0] REQ_MEAN   = 2'd0;
    localparam logic [1:0] REQ_ICOV   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Control of the shared multiplier and the accumulator.
    typedef struct packed {
        logic clr;
        logic mul_en;
        logic add_en;
        logic add_hi;
    } mac_ctl_t;

    // Drops the fraction bits and saturates the exact sum to the distance range.
    function automatic logic [DIST_W-1:0] sat_dist(input logic signed [ACC_W-1:0] acc);
        logic [DIST_W-1:0] res;
        if (acc[ACC_W-1]) begin
            res = '0;
        end else if (|acc[ACC_W-2:DIST_W+FRAC_W]) begin
            res = '1;
        end else begin
            res = acc[DIST_W+FRAC_W-1:FRAC_W];
        end
        return res;
    endfunction

endpackage

>>> sv/mnb_mac.sv
`timescale 1ns / 1ps

module mnb_mac (
    input  logic                                   aclk,
    input  mnb_pkg::mac_ctl_t                      ctl,
    input  logic signed [mnb_pkg::DIFF_W-1:0]      op_a,
    input  logic signed [mnb_pkg::DIFF_W-1:0]      op_b,
    output logic signed [mnb_pkg::PROD_W-1:0]      prod_reg,
    output logic signed [mnb_pkg::ACC_W-1:0]       acc_reg
);
    import mnb_pkg::*;

    logic signed [ACC_W-1:0] addend;

    // The high partial product carries a weight of 2^32.
    always_comb begin
        addend = ACC_W'(prod_reg);
        if (ctl.add_hi) begin
            addend = addend <<< HALF_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.add_en) begin
            acc_reg <= acc_reg + addend;
        end
    end

endmodule

>>> sv/mahalanobis_nearest_bin.sv
`timescale 1ns / 1ps
// Channel   Direction  Transaction
// s_        in         one load element or one query element (tuser = request kind)
// m_        out        nearest bin and its distance, one per query marked tlast
// cfg_      in         number of bins searched, written with cfg_we
//
// Loads and non-final query elements are accepted back to back while idle.
// For each bin a search forms the differences, fetches the first matrix element,
// works through each matrix term on the shared 33x33 multiplier and then
// compares; the result then goes to the output register once that is free.
// Reset is synchronous and active low; the tables are undefined until loaded.
// s_tready is low from a final query element until its result is in the output
// register; a result waiting there does not block loads.

module mahalanobis_nearest_bin (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // bin_index[3:0], row[5:4], col[7:6], value[39:8]
    input  logic [39:0]               s_tdata,
    // req_type[1:0]
    input  logic [1:0]                s_tuser,
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // best_bin[3:0], best_distance[66:4], zero fill above
    output logic [71:0]               m_tdata,
    input  logic                      cfg_we,
    input  logic [mnb_pkg::CFG_W-1:0] cfg_wdata
);
    import mnb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF_RD, ST_DIFF_WR, ST_T_RD, ST_T_M1, ST_T_M2,
        ST_T_M3, ST_T_M4, ST_BIN_END, ST_OUT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]          bins_reg;
    logic [BIN_W-1:0]          bin_reg;
    logic [ROW_W-1:0]          k_reg;
    logic [2*ROW_W-1:0]        idx_reg;
    logic [DIST_W-1:0]         best_dist_reg;
    logic [BIN_W-1:0]          best_bin_reg;
    logic signed [DIFF_W-1:0]  p1_hi_reg;
    logic [VAL_W-1:0]          q_reg [DIM];
    logic signed [DIFF_W-1:0]  d_reg [DIM];
    logic                      m_tvalid_reg;
    logic [71:0]               m_tdata_reg;

    // Tables: mean vectors and inverse covariance matrices.
    logic [VAL_W-1:0] mean_mem [NBINS*DIM];
    logic [VAL_W-1:0] icov_mem [NBINS*DIM*DIM];
    logic [VAL_W-1:0] mean_q;
    logic [VAL_W-1:0] icov_q;

    logic [BIN_W-1:0]       in_bin;
    logic [ROW_W-1:0]       in_row;
    logic [ROW_W-1:0]       in_col;
    logic [VAL_W-1:0]       in_value;
    logic                   accept;
    logic [BIN_W-1:0]       last_bin;
    logic [2*ROW_W-1:0]     icov_idx;
    logic [ROW_W-1:0]       d_sel;
    mac_ctl_t               mac_ctl;
    logic signed [DIFF_W-1:0] op_a;
    logic signed [DIFF_W-1:0] op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic [DIST_W-1:0]      bin_dist;
    logic                   out_free;

    assign in_bin   = s_tdata[3:0];
    assign in_row   = s_tdata[5:4];
    assign in_col   = s_tdata[7:6];
    assign in_value = s_tdata[39:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign bin_dist = sat_dist(acc);

    // A count of zero searches one bin, counts above the table size search all.
    always_comb begin
        if (bins_reg == '0) begin
            last_bin = '0;
        end else if (bins_reg > CFG_W'(NBINS)) begin
            last_bin = BIN_W'(NBINS - 1);
        end else begin
            last_bin = BIN_W'(bins_reg - CFG_W'(1));
        end
    end

    // The last step of a term already fetches the next matrix element.
    assign icov_idx = (state_reg == ST_T_M4) ? idx_reg + 1'b1 : idx_reg;

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == REQ_MEAN) begin
            mean_mem[{in_bin, in_row}] <= in_value;
        end
        mean_q <= mean_mem[{bin_reg, k_reg}];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == REQ_ICOV) begin
            icov_mem[{in_bin, in_row, in_col}] <= in_value;
        end
        icov_q <= icov_mem[{bin_reg, icov_idx}];
    end

    // Term icov[i][j]*d[i]*d[j]: first c*d[i], then the low and high halves
    // of that product times d[j], each added with its weight.
    always_comb begin
        mac_ctl = '0;
        d_sel   = idx_reg[ROW_W-1:0];
        op_a    = {1'b0, prod[HALF_W-1:0]};
        unique case (state_reg)
            ST_DIFF_RD: begin
                mac_ctl.clr = 1'b1;
            end
            ST_T_M1: begin
                d_sel          = idx_reg[2*ROW_W-1:ROW_W];
                op_a           = DIFF_W'(signed'(icov_q));
                mac_ctl.mul_en = 1'b1;
            end
            ST_T_M2: begin
                mac_ctl.mul_en = 1'b1;
            end
            ST_T_M3: begin
                op_a           = p1_hi_reg;
                mac_ctl.mul_en = 1'b1;
                mac_ctl.add_en = 1'b1;
            end
            ST_T_M4: begin
                mac_ctl.add_en = 1'b1;
                mac_ctl.add_hi = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign op_b = d_reg[d_sel];

    mnb_mac u_mac (
        .aclk     (aclk),
        .ctl      (mac_ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod),
        .acc_reg  (acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bins_reg     <= CFG_W'(NBINS);
            m_tvalid_reg <= 1'b0;
            bin_reg      <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
        end else begin
            if (cfg_we) begin
                bins_reg <= cfg_wdata;
            end
            // The output state reloads the register itself when it frees up.
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_tuser == REQ_QUERY) begin
                        q_reg[in_row] <= in_value;
                        if (s_tlast) begin
                            bin_reg   <= '0;
                            k_reg     <= '0;
                            state_reg <= ST_DIFF_RD;
                        end
                    end
                end
                ST_DIFF_RD: begin
                    state_reg <= ST_DIFF_WR;
                end
                ST_DIFF_WR: begin
                    d_reg[k_reg] <= DIFF_W'(signed'(q_reg[k_reg]))
                                  - DIFF_W'(signed'(mean_q));
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == ROW_W'(DIM - 1)) begin
                        idx_reg   <= '0;
                        state_reg <= ST_T_RD;
                    end else begin
                        state_reg <= ST_DIFF_RD;
                    end
                end
                ST_T_RD: begin
                    state_reg <= ST_T_M1;
                end
                ST_T_M1: begin
                    state_reg <= ST_T_M2;
                end
                ST_T_M2: begin
                    p1_hi_reg <= prod[PROD_W-2:HALF_W];
                    state_reg <= ST_T_M3;
                end
                ST_T_M3: begin
                    state_reg <= ST_T_M4;
                end
                ST_T_M4: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == '1) begin
                        state_reg <= ST_BIN_END;
                    end else begin
                        state_reg <= ST_T_M1;
                    end
                end
                ST_BIN_END: begin
                    // Bin zero sets the first best; after it only a strictly smaller distance replaces it.
                    if (bin_reg == '0 || bin_dist < best_dist_reg) begin
                        best_dist_reg <= bin_dist;
                        best_bin_reg  <= bin_reg;
                    end
                    k_reg <= '0;
                    if (bin_reg == last_bin) begin
                        state_reg <= ST_OUT;
                    end else begin
                        bin_reg   <= bin_reg + 1'b1;
                        state_reg <= ST_DIFF_RD;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, best_dist_reg, best_bin_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // The bin counter never runs past the last bin in use during a search.
    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (bin_reg <= last_bin))
        else $error("bin counter beyond bins in use");

    // A final query element starts a search that holds off further input.
    a_search_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_QUERY && s_tlast) |=> !s_tready)
        else $error("search did not start");

    // The last step of a term goes on to the next term or closes the bin.
    a_term_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_T_M4) |=> (state_reg == ST_T_M1 || state_reg == ST_BIN_END))
        else $error("term sequence broken");
`endif

endmodule

>>> tb/sv/mnb_nearest_checker.sv
`timescale 1ns / 1ps

module mnb_nearest_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [39:0]               s_tdata,
    input  logic [1:0]                s_tuser,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [71:0]               m_tdata,
    input  logic                      cfg_we,
    input  logic [mnb_pkg::CFG_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        pending_count
);
    import mnb_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [DIST_W-1:0] distance;
    } nearest_t;

    logic [VAL_W-1:0] mean_tbl [NBINS*DIM];
    logic [VAL_W-1:0] icov_tbl [NBINS*DIM*DIM];
    logic [VAL_W-1:0] query_vec [DIM];
    logic [CFG_W-1:0] bins_cfg;
    nearest_t         expected_nearest [$];

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Exact quadratic form, floor of the Q80.48 sum to Q31.32, then saturated.
    function automatic logic [DIST_W-1:0] predict_distance(input int b);
        logic signed [127:0]     sum;
        logic signed [127:0]     scaled;
        logic signed [VAL_W:0]   d [DIM];
        logic signed [VAL_W-1:0] c;
        logic [DIST_W-1:0]       res;
        sum = '0;
        for (int i = 0; i < DIM; i++) begin
            d[i] = $signed({query_vec[i][VAL_W-1], query_vec[i]})
                 - $signed({mean_tbl[b*DIM+i][VAL_W-1], mean_tbl[b*DIM+i]});
        end
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                c = $signed(icov_tbl[(b*DIM+i)*DIM+j]);
                sum = sum + c * d[i] * d[j];
            end
        end
        scaled = sum >>> FRAC_W;
        if (sum < 0) res = '0;
        else if (scaled > $signed({65'd0, {DIST_W{1'b1}}})) res = '1;
        else res = scaled[DIST_W-1:0];
        return res;
    endfunction

    function automatic nearest_t search_nearest();
        nearest_t best;
        int n;
        logic [DIST_W-1:0] cand;
        n = bins_cfg;
        if (n == 0) n = 1;
        if (n > NBINS) n = NBINS;
        best.bin      = '0;
        best.distance = predict_distance(0);
        for (int b = 1; b < n; b++) begin
            cand = predict_distance(b);
            if (cand < best.distance) begin
                best.distance = cand;
                best.bin      = BIN_W'(b);
            end
        end
        return best;
    endfunction

    always @(posedge aclk) begin
        logic [BIN_W-1:0] bin;
        logic [1:0]       row;
        logic [1:0]       col;
        logic [VAL_W-1:0] val;
        nearest_t         exp_item;
        if (!aresetn) begin
            bins_cfg = CFG_W'(NBINS);
        end else begin
            if (cfg_we) bins_cfg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                bin = s_tdata[3:0];
                row = s_tdata[5:4];
                col = s_tdata[7:6];
                val = s_tdata[39:8];
                case (s_tuser)
                    REQ_MEAN: mean_tbl[bin*DIM+row] = val;
                    REQ_ICOV: icov_tbl[(bin*DIM+row)*DIM+col] = val;
                    REQ_QUERY: begin
                        query_vec[row] = val;
                        if (s_tlast) expected_nearest = {expected_nearest, search_nearest()};
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_nearest.size() == 0) begin
                    report("result with no query waiting");
                end else begin
                    exp_item = expected_nearest.pop_front();
                    if (m_tdata[3:0] !== exp_item.bin)
                        report($sformatf("best_bin %0d, expected %0d",
                                         m_tdata[3:0], exp_item.bin));
                    if (m_tdata[66:4] !== exp_item.distance)
                        report($sformatf("best_distance %h, expected %h",
                                         m_tdata[66:4], exp_item.distance));
                    if (m_tdata[71:67] !== '0)
                        report("nonzero fill above best_distance");
                end
            end
        end
        pending_count = expected_nearest.size();
    end

endmodule

>>> tb/sv/tb_mahalanobis_nearest_bin.sv
`timescale 1ns / 1ps

module tb_mahalanobis_nearest_bin;
    import mnb_pkg::*;

    // This wait covers a full 16-bin search with margin.
    localparam int SEARCH_WAIT = 1500;
    localparam int CYCLE_LIMIT = 10000000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata = '0;
    logic [1:0]          s_tuser = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [71:0]         m_tdata;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    int                  fail_count;
    int                  pending_count;
    int                  cycle_count = 0;
    int                  burst_left = 0;

    always #10 aclk = ~aclk;

    mahalanobis_nearest_bin DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    mnb_nearest_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mahalanobis_nearest_bin test failed");
            $finish;
        end
    end

    // The receiver keeps switching between random stall patterns. Once, well into the
    // random part, it holds off for a long stretch so that a result backs up and
    // the block stalls its input while the sender keeps offering transactions.
    initial begin
        int mode;
        int rx_cycles;
        rx_cycles = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            repeat (64) begin
                @(posedge aclk);
                rx_cycles++;
                if (rx_cycles == 30000) begin
                    m_tready <= 1'b0;
                    repeat (4000) @(posedge aclk);
                    rx_cycles++;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 0);
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Sends one transaction. The sender works in bursts with random gaps between
    // them; ready is sampled on the falling edge, where it is stable.
    task automatic send_item(input logic [1:0] req, input logic [3:0] bin,
                             input logic [1:0] row, input logic [1:0] col,
                             input logic [31:0] val, input logic last);
        logic taken;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {val, col, row, bin};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // Waits until every result has arrived and the block has had time to finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SEARCH_WAIT) @(posedge aclk);
    endtask

    task automatic write_bins(input logic [CFG_W-1:0] n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly modest values so distances stay comparable, with some full range
    // and extreme values to drive saturation and negative sums.
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return 32'($signed($urandom_range(0, 262143)) - 131072);
        if (sel < 7) return 32'($signed($urandom_range(0, 33554431)) - 16777216);
        if (sel < 9) return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
    endfunction

    task automatic send_query_vector(input int extreme);
        logic [31:0] v;
        for (int r = 0; r < DIM; r++) begin
            case (extreme)
                1: v = 32'h7FFFFFFF;
                2: v = 32'h80000000;
                default: v = pick_value();
            endcase
            send_item(REQ_QUERY, 4'($urandom), 2'(r), 2'($urandom), v, r == DIM - 1);
        end
    endtask

    task automatic random_phase(input int count);
        int sel;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 7) begin
                send_item(REQ_MEAN, 4'($urandom), 2'($urandom), 2'($urandom),
                          pick_value(), 1'($urandom));
            end else if (sel < 14) begin
                send_item(REQ_ICOV, 4'($urandom), 2'($urandom), 2'($urandom),
                          pick_value(), 1'($urandom));
            end else if (sel < 17) begin
                send_item(REQ_QUERY, 4'($urandom), 2'($urandom), 2'($urandom),
                          pick_value(), ($urandom_range(0, 2) == 0));
            end else if (sel < 19) begin
                send_query_vector(0);
                k += DIM - 1;
            end else begin
                send_item(REQ_UNUSED, 4'($urandom), 2'($urandom), 2'($urandom),
                          $urandom, 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_bins(5'd16);

        // Every table entry is written before the first search reads it; all bins
        // start out identical, so the first searches tie and must pick bin zero.
        for (int b = 0; b < NBINS; b++) begin
            for (int r = 0; r < DIM; r++) begin
                send_item(REQ_MEAN, 4'(b), 2'(r), 2'($urandom), 32'h00010000, 1'b0);
                for (int c = 0; c < DIM; c++)
                    send_item(REQ_ICOV, 4'(b), 2'(r), 2'(c),
                              (r == c) ? 32'h00010000 : 32'h0, 1'b0);
            end
        end
        send_query_vector(0);

        // Directed: extremes of the query, extreme means and a negative matrix,
        // last on loads, an unused request type, and a tie-break.
        send_query_vector(1);
        send_query_vector(2);
        send_item(REQ_MEAN, 4'd15, 2'd3, 2'd3, 32'h80000000, 1'b1);
        send_item(REQ_MEAN, 4'd15, 2'd0, 2'd0, 32'h7FFFFFFF, 1'b0);
        send_item(REQ_ICOV, 4'd15, 2'd3, 2'd3, 32'h80000000, 1'b1);
        send_item(REQ_UNUSED, 4'd15, 2'd3, 2'd3, 32'hFFFFFFFF, 1'b1);
        send_item(REQ_ICOV, 4'd1, 2'd0, 2'd0, 32'hFFFF0000, 1'b0);
        send_item(REQ_QUERY, 4'd0, 2'd0, 2'd0, 32'h7FFFFFFF, 1'b1);
        send_item(REQ_QUERY, 4'd0, 2'd0, 2'd0, 32'h00010000, 1'b1);
        send_item(REQ_MEAN, 4'd2, 2'd1, 2'd0, 32'h00000000, 1'b0);
        send_item(REQ_QUERY, 4'd0, 2'd1, 2'd0, 32'h00000000, 1'b1);

        random_phase(180);
        write_bins(5'd1);
        random_phase(150);
        write_bins(5'd0);
        random_phase(110);
        write_bins(5'd31);
        random_phase(180);
        write_bins(5'd5);
        random_phase(180);
        write_bins(5'd17);
        random_phase(110);
        write_bins(5'd16);
        random_phase(200);

        drain();
        if (fail_count == 0) begin
            $display("mahalanobis_nearest_bin test passed");
        end else begin
            $display("mahalanobis_nearest_bin test failed");
        end
        $finish;
    end

endmodule
